FILE: sv/lsp_pkg.sv
// Shared constants, codes and types for the line sensor position block.
`timescale 1ns / 1ps

package lsp_pkg;

    // Default build values
    localparam int SENSOR_COUNT_DEF = 8;
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int FULL_SCALE_DEF   = 1000;

    // Fixed field widths
    localparam int IDX_BITS      = 3;
    localparam int OPCODE_BITS   = 2;
    localparam int VALUE_W       = 10;   // mapped value and thresholds
    localparam int POSITION_W    = 13;
    localparam int DETECTED_W    = 4;
    localparam int IN_USER_W     = 3;
    localparam int OUT_DATA_W    = 24;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 10;

    // Position scale: one sensor spacing
    localparam int POS_STEP  = 1000;
    localparam int HALF_STEP = 500;

    // Opcodes
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CALIBRATE = 2'd0,
        OP_MEASURE   = 2'd1,
        OP_LOAD_LOW  = 2'd2,
        OP_LOAD_HIGH = 2'd3
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WHITE_LINE       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DETECT_THRESHOLD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EDGE_THRESHOLD   = 2'd2;

    // Register reset values
    localparam logic                WHITE_LINE_RST       = 1'b0;
    localparam logic [VALUE_W-1:0]  DETECT_THRESHOLD_RST = 10'd400;
    localparam logic [VALUE_W-1:0]  EDGE_THRESHOLD_RST   = 10'd250;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: sv/lsp_div.sv
// Restoring divider, one quotient bit per cycle, shared by the map and centroid steps.
`timescale 1ns / 1ps

module lsp_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output lsp_pkg::div_stat_t   stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;

    // Trial subtract of the next partial remainder
    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quo_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                quo_reg <= {quo_reg[NUM_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: sv/lsp_bounds.sv
// Per-sensor low and high calibration bounds with calibrate and load updates.
`timescale 1ns / 1ps

module lsp_bounds #(
    parameter int DEPTH       = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  lsp_pkg::opcode_t              op,
    input  logic                          first_sweep,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    input  logic [SAMPLE_BITS-1:0]        sample,
    output logic [SAMPLE_BITS-1:0]        low_bound,
    output logic [SAMPLE_BITS-1:0]        high_bound
);

    logic [SAMPLE_BITS-1:0] low_reg  [DEPTH];
    logic [SAMPLE_BITS-1:0] high_reg [DEPTH];

    // Read at the item's sensor
    assign low_bound  = low_reg[addr];
    assign high_bound = high_reg[addr];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                low_reg[k]  <= '1;
                high_reg[k] <= '0;
            end
        end else if (wr_en) begin
            unique case (op)
                lsp_pkg::OP_CALIBRATE: begin
                    if (first_sweep) begin
                        low_reg[addr]  <= sample;
                        high_reg[addr] <= sample;
                    end else begin
                        // widen the pair so the sample lies inside
                        if (sample < low_bound)  low_reg[addr]  <= sample;
                        if (sample > high_bound) high_reg[addr] <= sample;
                    end
                end
                lsp_pkg::OP_LOAD_LOW:  low_reg[addr]  <= sample;
                lsp_pkg::OP_LOAD_HIGH: high_reg[addr] <= sample;
                default: ;
            endcase
        end
    end

endmodule

FILE: sv/line_sensor_position.sv
// Top level: reflectance sensor array line position with calibration and centroid.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata idx,sample; tuser op,first; tlast
//  m_       | out       | m_tvalid/m_tready  | tdata position,on_line,detected,last_idx
//  cfg_     | in        | cfg_we             | cfg_addr, cfg_wdata
//
//  Calibrate and load items are written straight into the bound tables. A measure
//  item runs the mapping step through the shared restoring divider when its bound pair
//  is not empty; a frame's last item adds a second pass of the same divider for the
//  centroid when it found an edge with nonzero weight. s_tready is low while an item works.
//  A finished result sits in the output register; the next item is taken while it
//  waits, and only a new result stalls on it. Reset is synchronous, no clearing pass.
`timescale 1ns / 1ps

module line_sensor_position #(
    parameter int SENSOR_COUNT = lsp_pkg::SENSOR_COUNT_DEF,
    parameter int SAMPLE_BITS  = lsp_pkg::SAMPLE_BITS_DEF,
    parameter int FULL_SCALE   = lsp_pkg::FULL_SCALE_DEF,
    localparam int IN_DATA_W   = ((lsp_pkg::IDX_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [IN_DATA_W-1:0]                 s_tdata,   // sensor_index, sample_value
    input  logic [lsp_pkg::IN_USER_W-1:0]        s_tuser,   // opcode, first_sweep
    input  logic                                 s_tlast,   // last_in_frame
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lsp_pkg::OUT_DATA_W-1:0]       m_tdata,   // position, on_line,
                                                             // sensors_detected,
                                                             // last_detected_index
    // configuration
    input  logic                                 cfg_we,
    input  logic [lsp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int VW          = lsp_pkg::VALUE_W;
    localparam int TABLE_DEPTH = (SENSOR_COUNT < 8) ? SENSOR_COUNT : 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TOP_POS     = (SENSOR_COUNT - 1) * lsp_pkg::POS_STEP;
    localparam int HALF_TOP    = (SENSOR_COUNT - 1) * lsp_pkg::HALF_STEP;
    localparam int POS_W       = $clog2(TOP_POS + 1);
    localparam int MAP_NUM_W   = $clog2(((1 << SAMPLE_BITS) - 1) * FULL_SCALE + 1);
    localparam int WSUM_W      = $clog2((SENSOR_COUNT * (SENSOR_COUNT - 1) / 2)
                                        * FULL_SCALE * lsp_pkg::POS_STEP + 1);
    localparam int WTOT_W      = $clog2(SENSOR_COUNT * FULL_SCALE + 1);
    localparam int DCNT_W      = $clog2(SENSOR_COUNT + 1);
    localparam int IDXW_W      = $clog2((TABLE_DEPTH - 1) * lsp_pkg::POS_STEP + 1);
    localparam int DIV_NUM_W   = (MAP_NUM_W > WSUM_W) ? MAP_NUM_W : WSUM_W;
    localparam int DIV_DEN_W   = (SAMPLE_BITS > WTOT_W) ? SAMPLE_BITS : WTOT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MAPDIV,
        ST_SCORE,
        ST_WEIGH,
        ST_CENT,
        ST_CENTDIV,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // Configuration registers
    logic          white_reg;
    logic [VW-1:0] det_thr_reg;
    logic [VW-1:0] edge_thr_reg;

    // Item registers
    logic [lsp_pkg::IDX_BITS-1:0] idx_reg;
    logic                         idx_zero_reg;
    logic                         last_reg;
    logic [SAMPLE_BITS-1:0]       x_reg;
    logic [SAMPLE_BITS-1:0]       lo_reg;
    logic [SAMPLE_BITS-1:0]       hi_reg;
    logic [VW-1:0]                mapped_reg;
    logic [VW-1:0]                v_reg;
    logic [IDXW_W-1:0]            idxw_reg;

    // Frame state
    logic [WSUM_W-1:0] wsum_reg;
    logic [WTOT_W-1:0] wtot_reg;
    logic [VW-1:0]     prev_reg;
    logic              edge_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [lsp_pkg::IDX_BITS-1:0] last_det_reg;
    logic [POS_W-1:0]  last_pos_reg;
    logic [POS_W-1:0]  pos_reg;

    // Output register
    logic                          m_tvalid_reg;
    logic [lsp_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Input field decode
    lsp_pkg::opcode_t             in_op;
    logic                         in_first;
    logic [lsp_pkg::IDX_BITS-1:0] in_idx;
    logic [SAMPLE_BITS-1:0]       in_x;
    logic [IDX_W-1:0]             in_addr;
    logic                         accept;
    logic                         idx_ok;

    assign in_op    = lsp_pkg::opcode_t'(s_tuser[lsp_pkg::OPCODE_BITS-1:0]);
    assign in_first = s_tuser[lsp_pkg::OPCODE_BITS];
    assign in_idx   = s_tdata[lsp_pkg::IDX_BITS-1:0];
    assign in_x     = s_tdata[lsp_pkg::IDX_BITS +: SAMPLE_BITS];
    assign in_addr  = IDX_W'(in_idx);
    assign idx_ok   = (32'(in_idx) < SENSOR_COUNT);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Bound tables
    logic [SAMPLE_BITS-1:0] tbl_lo;
    logic [SAMPLE_BITS-1:0] tbl_hi;

    lsp_bounds #(
        .DEPTH       (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_bounds (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (accept && idx_ok && (in_op != lsp_pkg::OP_MEASURE)),
        .op          (in_op),
        .first_sweep (in_first),
        .addr        (in_addr),
        .sample      (in_x),
        .low_bound   (tbl_lo),
        .high_bound  (tbl_hi)
    );

    // Mapping numerator: clamp, offset, scale
    logic                   pair_empty;
    logic [SAMPLE_BITS-1:0] x_clamp;
    logic [MAP_NUM_W-1:0]   map_num;

    always_comb begin
        pair_empty = (hi_reg <= lo_reg);
        if (x_reg < lo_reg) begin
            x_clamp = lo_reg;
        end else if (x_reg > hi_reg) begin
            x_clamp = hi_reg;
        end else begin
            x_clamp = x_reg;
        end
        map_num = MAP_NUM_W'((x_clamp - lo_reg) * FULL_SCALE);
    end

    // Shared divider
    logic                  div_start;
    logic [DIV_NUM_W-1:0]  div_num;
    logic [DIV_DEN_W-1:0]  div_den;
    logic [DIV_NUM_W-1:0]  div_quo;
    lsp_pkg::div_stat_t    div_stat;

    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_NUM_W'(map_num);
        div_den   = DIV_DEN_W'(hi_reg - lo_reg);
        if (state_reg == ST_MAP) begin
            div_start = !pair_empty;
        end else if (state_reg == ST_CENT) begin
            div_start = 1'b1;
            div_num   = DIV_NUM_W'(wsum_reg);
            div_den   = DIV_DEN_W'(wtot_reg);
        end
    end

    lsp_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Threshold and neighbour step of the mapped value
    logic [VW-1:0] frac;
    logic          detected;
    logic [VW-1:0] v_score;
    logic [VW-1:0] step;

    always_comb begin
        frac     = div_quo[VW-1:0];
        detected = !(mapped_reg < det_thr_reg);
        v_score  = detected ? mapped_reg : '0;
        step     = (v_score > prev_reg) ? (v_score - prev_reg) : (prev_reg - v_score);
    end

    // Sequencer, frame state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            white_reg    <= lsp_pkg::WHITE_LINE_RST;
            det_thr_reg  <= lsp_pkg::DETECT_THRESHOLD_RST;
            edge_thr_reg <= lsp_pkg::EDGE_THRESHOLD_RST;
            wsum_reg     <= '0;
            wtot_reg     <= '0;
            prev_reg     <= '0;
            edge_reg     <= 1'b0;
            dcnt_reg     <= '0;
            last_det_reg <= '0;
            last_pos_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_addr)
                    lsp_pkg::REG_WHITE_LINE:       white_reg    <= cfg_wdata[0];
                    lsp_pkg::REG_DETECT_THRESHOLD: det_thr_reg  <= cfg_wdata[VW-1:0];
                    lsp_pkg::REG_EDGE_THRESHOLD:   edge_thr_reg <= cfg_wdata[VW-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && idx_ok && (in_op == lsp_pkg::OP_MEASURE)) begin
                        idx_reg      <= in_idx;
                        idx_zero_reg <= (in_idx == '0);
                        last_reg     <= s_tlast;
                        x_reg        <= in_x;
                        lo_reg       <= tbl_lo;
                        hi_reg       <= tbl_hi;
                        // a frame starts at sensor zero
                        if (in_idx == '0) begin
                            wsum_reg <= '0;
                            wtot_reg <= '0;
                            prev_reg <= '0;
                            edge_reg <= 1'b0;
                            dcnt_reg <= '0;
                        end
                        state_reg <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    if (pair_empty) begin
                        mapped_reg <= '0;
                        state_reg  <= ST_SCORE;
                    end else begin
                        state_reg  <= ST_MAPDIV;
                    end
                end
                ST_MAPDIV: begin
                    if (div_stat.done) begin
                        mapped_reg <= white_reg ? frac : (VW'(FULL_SCALE) - frac);
                        state_reg  <= ST_SCORE;
                    end
                end
                ST_SCORE: begin
                    v_reg    <= v_score;
                    idxw_reg <= IDXW_W'(idx_reg * lsp_pkg::POS_STEP);
                    wtot_reg <= wtot_reg + WTOT_W'(v_score);
                    prev_reg <= v_score;
                    if (detected) begin
                        dcnt_reg     <= dcnt_reg + 1'b1;
                        last_det_reg <= idx_reg;
                    end
                    if (!idx_zero_reg && (step > edge_thr_reg)) begin
                        edge_reg <= 1'b1;
                    end
                    state_reg <= ST_WEIGH;
                end
                ST_WEIGH: begin
                    wsum_reg <= wsum_reg + WSUM_W'(idxw_reg * v_reg);
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (edge_reg) begin
                        if (wtot_reg == '0) begin
                            pos_reg      <= '0;
                            last_pos_reg <= '0;
                            state_reg    <= ST_EMIT;
                        end else begin
                            state_reg    <= ST_CENT;
                        end
                    end else begin
                        // no line: report the nearer end
                        pos_reg   <= (32'(last_pos_reg) < HALF_TOP) ? '0 : POS_W'(TOP_POS);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_CENT: begin
                    state_reg <= ST_CENTDIV;
                end
                ST_CENTDIV: begin
                    if (div_stat.done) begin
                        pos_reg      <= POS_W'(div_quo);
                        last_pos_reg <= POS_W'(div_quo);
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= lsp_pkg::OUT_DATA_W'({
                            last_det_reg,
                            lsp_pkg::DETECTED_W'(dcnt_reg),
                            edge_reg,
                            lsp_pkg::POSITION_W'(pos_reg)
                        });
                        wsum_reg  <= '0;
                        wtot_reg  <= '0;
                        prev_reg  <= '0;
                        edge_reg  <= 1'b0;
                        dcnt_reg  <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // divider never runs while a new item can be taken
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while input ready");

    // divider finishes only in a state that waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_MAPDIV || state_reg == ST_CENTDIV))
        else $error("divider result with nobody waiting");

    // weighted sum grows only with a nonzero weight total
    a_wsum: assert property (@(posedge aclk) disable iff (!aresetn)
        (wtot_reg == '0) |-> (wsum_reg == '0))
        else $error("weighted sum without weight");

    // detections never outnumber the sensors
    a_dcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(dcnt_reg) <= SENSOR_COUNT)
        else $error("detection count overflow");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for line_sensor_position: directed table, then random phases.
`timescale 1ns / 1ps

module tb;
    import lsp_pkg::*;

    localparam int SENSORS     = SENSOR_COUNT_DEF;
    localparam int FULL        = FULL_SCALE_DEF;
    localparam int IN_DATA_W   = 16;
    localparam int PHASE_ITEMS = 180;
    localparam int SETTLE_CYC  = 100;   // idle time after the last pending result

    // One input item as the block sees it
    typedef struct packed {
        opcode_t     op;
        logic        first;
        logic [2:0]  idx;
        logic [11:0] sample;
        logic        last;
    } sensor_item_t;

    // One frame result
    typedef struct packed {
        logic [12:0] pos;
        logic        on_line;
        logic [3:0]  detected;
        logic [2:0]  last_idx;
    } line_result_t;

    // Directed row: item plus an optional hand-written expectation
    typedef struct packed {
        sensor_item_t item;
        logic         typed;
        line_result_t want;
    } dir_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // sensor_index, sample_value
    logic [IN_USER_W-1:0]  s_tuser  = '0;   // opcode, first_sweep
    logic                  s_tlast  = 1'b0; // last_in_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // position, on_line, sensors_detected,
                                            // last_detected_index
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    line_sensor_position u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Overall time limit
    initial begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Position predictor: its own copy of tables, frame state and registers
    // ------------------------------------------------------------------
    logic              cfg_white  = WHITE_LINE_RST;
    logic [9:0]        cfg_detect = DETECT_THRESHOLD_RST;
    logic [9:0]        cfg_edge   = EDGE_THRESHOLD_RST;
    logic [11:0]       cal_low  [SENSORS];
    logic [11:0]       cal_high [SENSORS];
    longint unsigned   acc_wsum      = 0;
    int unsigned       acc_weight    = 0;
    logic [9:0]        prev_level    = '0;
    logic              edge_hit      = 1'b0;
    logic [4:0]        hits          = '0;
    logic [2:0]        last_hit_idx  = '0;
    int unsigned       held_position = 0;
    int unsigned       acc_count     = 0;   // measure items folded in since the last clear

    line_result_t pending_positions[$];
    int           error_count = 0;
    int           items_sent  = 0;
    bit           gaps_on     = 1'b1;

    initial begin
        for (int k = 0; k < SENSORS; k++) begin
            cal_low[k]  = 12'hFFF;
            cal_high[k] = 12'h000;
        end
    end

    function automatic void clear_frame_acc();
        acc_wsum   = 0;
        acc_weight = 0;
        prev_level = '0;
        edge_hit   = 1'b0;
        hits       = '0;
        acc_count  = 0;
    endfunction

    // Clamp to the bounds and scale onto 0..FULL; an empty bound pair gives 0
    function automatic logic [9:0] scale_reading(input logic [11:0] x, input logic [11:0] lo,
                                                 input logic [11:0] hi);
        int unsigned xc;
        int unsigned frac;
        if (hi <= lo) return 10'd0;
        xc = x;
        if (x < lo) xc = lo;
        if (x > hi) xc = hi;
        frac = ((xc - lo) * FULL) / (hi - lo);
        return cfg_white ? 10'(frac) : 10'(FULL - frac);
    endfunction

    // Apply one item; returns 1 with the frame result when one is due
    function automatic bit predict_position(input sensor_item_t it, output line_result_t res);
        logic [9:0]  lvl;
        int unsigned diff;
        int unsigned pos;
        res = '0;
        if (it.idx >= SENSORS) return 1'b0;
        case (it.op)
            OP_CALIBRATE: begin
                if (it.first) begin
                    cal_low[it.idx]  = it.sample;
                    cal_high[it.idx] = it.sample;
                end else begin
                    if (it.sample < cal_low[it.idx])  cal_low[it.idx]  = it.sample;
                    if (it.sample > cal_high[it.idx]) cal_high[it.idx] = it.sample;
                end
                return 1'b0;
            end
            OP_LOAD_LOW: begin
                cal_low[it.idx] = it.sample;
                return 1'b0;
            end
            OP_LOAD_HIGH: begin
                cal_high[it.idx] = it.sample;
                return 1'b0;
            end
            default: ;
        endcase

        // measure: sensor 0 opens a new frame
        if (it.idx == 0) clear_frame_acc();
        lvl = scale_reading(it.sample, cal_low[it.idx], cal_high[it.idx]);
        if (lvl < cfg_detect) begin
            lvl = '0;
        end else begin
            hits         = hits + 5'd1;
            last_hit_idx = it.idx;
        end
        acc_wsum   += 64'(it.idx) * 64'(lvl) * 64'(POS_STEP);
        acc_weight += lvl;
        if (it.idx != 0) begin
            diff = (lvl > prev_level) ? lvl - prev_level : prev_level - lvl;
            if (diff > cfg_edge) edge_hit = 1'b1;
        end
        prev_level = lvl;
        acc_count++;
        if (!it.last) return 1'b0;

        // frame end: centroid, or the nearer end of the array with no edge
        if (edge_hit) begin
            pos = (acc_weight != 0) ? 32'(acc_wsum / acc_weight) : 0;
            held_position = pos;
        end else begin
            pos = (held_position < (SENSORS - 1) * HALF_STEP) ? 0 : (SENSORS - 1) * POS_STEP;
        end
        res.pos      = pos[12:0];
        res.on_line  = edge_hit;
        res.detected = hits[3:0];
        res.last_idx = last_hit_idx;
        clear_frame_acc();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_result(input logic [OUT_DATA_W-1:0] word);
        line_result_t want;
        if (pending_positions.size() == 0) begin
            report_error($sformatf("result with nothing pending, tdata %h", word));
            return;
        end
        want = pending_positions.pop_front();
        if (word[12:0] !== want.pos)
            report_error($sformatf("position %0d, expected %0d", word[12:0], want.pos));
        if (word[13] !== want.on_line)
            report_error($sformatf("on_line %0d, expected %0d", word[13], want.on_line));
        if (word[17:14] !== want.detected)
            report_error($sformatf("sensors_detected %0d, expected %0d",
                                   word[17:14], want.detected));
        if (word[20:18] !== want.last_idx)
            report_error($sformatf("last_detected_index %0d, expected %0d",
                                   word[20:18], want.last_idx));
        if (word[23:21] !== 3'd0)
            report_error($sformatf("padding bits %b not zero", word[23:21]));
    endtask

    // Result side: random backpressure, check every accepted item
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result(m_tdata);
            m_tready <= !(gaps_on && $urandom_range(99) < 38);
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    function automatic sensor_item_t make_item(input opcode_t op, input logic first,
                                               input logic [2:0] idx, input logic [11:0] s,
                                               input logic last);
        sensor_item_t it;
        it.op     = op;
        it.first  = first;
        it.idx    = idx;
        it.sample = s;
        it.last   = last;
        return it;
    endfunction

    // Present one item, wait for the handshake, then predict it
    task automatic send_item(input sensor_item_t it, input logic typed, input line_result_t want);
        line_result_t res;
        while (gaps_on && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, it.sample, it.idx};
        s_tuser  <= {it.first, it.op};
        s_tlast  <= it.last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (predict_position(it, res))
            pending_positions.push_back(typed ? want : res);
    endtask

    // Stop sending, let every pending result arrive and the block go quiet
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic apply_config(input logic white, input logic [9:0] det, input logic [9:0] edg);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WHITE_LINE;
        cfg_wdata <= {9'd0, white};
        @(posedge aclk);
        cfg_addr  <= REG_DETECT_THRESHOLD;
        cfg_wdata <= det;
        @(posedge aclk);
        cfg_addr  <= REG_EDGE_THRESHOLD;
        cfg_wdata <= edg;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_white  = white;
        cfg_detect = det;
        cfg_edge   = edg;
    endtask

    // Samples mostly inside the sensor's current bounds, plus the rails
    function automatic logic [11:0] pick_sample(input logic [2:0] idx);
        int unsigned r;
        r = $urandom_range(15);
        if (r == 0) return 12'd0;
        if (r == 1) return 12'hFFF;
        if (r < 12 && cal_low[idx] < cal_high[idx])
            return 12'($urandom_range(cal_high[idx], cal_low[idx]));
        return 12'($urandom_range(4095));
    endfunction

    task automatic calibration_sweep();
        for (int k = 0; k < SENSORS; k++) begin
            send_item(make_item(OP_CALIBRATE, 1'b1, 3'(k), 12'($urandom_range(4095)),
                                1'($urandom_range(1))), 1'b0, '0);
            repeat ($urandom_range(3, 1))
                send_item(make_item(OP_CALIBRATE, 1'b0, 3'(k), 12'($urandom_range(4095)),
                                    1'($urandom_range(1))), 1'b0, '0);
        end
    endtask

    // Direct bound load; now and then an inverted or empty pair
    task automatic load_bounds();
        logic [2:0]  idx;
        logic [11:0] a;
        logic [11:0] b;
        idx = 3'($urandom_range(SENSORS - 1));
        a   = 12'($urandom_range(2000));
        b   = 12'($urandom_range(4095, 2000));
        if ($urandom_range(5) == 0) begin
            a = b;
            b = 12'($urandom_range(4095));
        end
        send_item(make_item(OP_LOAD_LOW, 1'($urandom_range(1)), idx, a,
                            1'($urandom_range(1))), 1'b0, '0);
        send_item(make_item(OP_LOAD_HIGH, 1'($urandom_range(1)), idx, b,
                            1'($urandom_range(1))), 1'b0, '0);
    endtask

    // Sensors in order from 0, a few skipped, sometimes cut short
    task automatic measure_frame();
        logic stop;
        for (int k = 0; k < SENSORS; k++) begin
            if (k != 0 && $urandom_range(9) == 0) continue;
            stop = (k == SENSORS - 1) || ($urandom_range(19) == 0);
            send_item(make_item(OP_MEASURE, 1'($urandom_range(1)), 3'(k), pick_sample(3'(k)),
                                stop), 1'b0, '0);
            if (stop) break;
        end
    endtask

    // Arbitrary items; a run of measures is closed before it outgrows one frame
    task automatic noise_item();
        sensor_item_t it;
        it = make_item(opcode_t'($urandom_range(3)), 1'($urandom_range(1)),
                       3'($urandom_range(SENSORS - 1)), 12'($urandom_range(4095)),
                       1'($urandom_range(1)));
        if (it.op == OP_MEASURE && it.idx != 0 && acc_count >= SENSORS - 1) it.last = 1'b1;
        send_item(it, 1'b0, '0);
    endtask

    task automatic random_phase(input int quota, input bit mid_pause);
        int          target;
        int unsigned r;
        bit          paused;
        target = items_sent + quota;
        paused = 1'b0;
        calibration_sweep();
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 6)       calibration_sweep();
            else if (r < 16) load_bounds();
            else if (r < 86) measure_frame();
            else             repeat ($urandom_range(4, 1)) noise_item();
            if (mid_pause && !paused && items_sent >= target - quota / 2) begin
                wait_drain();
                paused = 1'b1;
            end
        end
    endtask

    // Directed table; expectations typed in only where obvious
    dir_row_t directed_rows [23] = '{
        // empty bounds after reset: nothing maps, no edge, low end
        '{'{OP_MEASURE,   1'b0, 3'd0, 12'd4095, 1'b1}, 1'b1, '{13'd0, 1'b0, 4'd0, 3'd0}},
        '{'{OP_LOAD_LOW,  1'b0, 3'd3, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_LOAD_HIGH, 1'b1, 3'd3, 12'd4095, 1'b1}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b1, 3'd0, 12'd100,  1'b0}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b0, 3'd0, 12'd4000, 1'b1}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b0, 3'd0, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b1, 3'd1, 12'd4095, 1'b0}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b1, 3'd7, 12'd2000, 1'b0}, 1'b0, '0},
        '{'{OP_CALIBRATE, 1'b0, 3'd7, 12'd3000, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD_LOW,  1'b0, 3'd2, 12'd3000, 1'b0}, 1'b0, '0},
        '{'{OP_LOAD_HIGH, 1'b0, 3'd2, 12'd1000, 1'b0}, 1'b0, '0},
        // frame with an empty pair, an inverted pair and a centroid
        '{'{OP_MEASURE,   1'b0, 3'd0, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd1, 12'd4095, 1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd2, 12'd2000, 1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd3, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd7, 12'd3000, 1'b1}, 1'b0, '0},
        // no edge with the last centroid low
        '{'{OP_MEASURE,   1'b0, 3'd4, 12'd2048, 1'b1}, 1'b0, '0},
        '{'{OP_LOAD_LOW,  1'b0, 3'd6, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_LOAD_HIGH, 1'b0, 3'd6, 12'd4095, 1'b0}, 1'b0, '0},
        // centroid near the high end, clamped sample on sensor 0
        '{'{OP_MEASURE,   1'b1, 3'd0, 12'd4095, 1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd6, 12'd0,    1'b0}, 1'b0, '0},
        '{'{OP_MEASURE,   1'b0, 3'd7, 12'd2000, 1'b1}, 1'b0, '0},
        // no edge with the last centroid high: far end, index held
        '{'{OP_MEASURE,   1'b0, 3'd5, 12'd0,    1'b1}, 1'b1, '{13'd7000, 1'b0, 4'd0, 3'd7}}
    };

    // Main sequence
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // default registers first, then the corners, then mid-range settings
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();
        apply_config(1'b1, 10'd0, 10'd0);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();
        apply_config(1'b0, 10'd1000, 10'd1000);
        random_phase(PHASE_ITEMS, 1'b0);
        wait_drain();
        apply_config(1'b1, 10'd1000, 10'd0);
        gaps_on = 1'b0;
        random_phase(PHASE_ITEMS, 1'b0);
        gaps_on = 1'b1;
        wait_drain();
        apply_config(1'b0, 10'd0, 10'd1000);
        random_phase(PHASE_ITEMS, 1'b1);
        repeat (2) begin
            wait_drain();
            apply_config(1'($urandom_range(1)), 10'($urandom_range(700, 200)),
                         10'($urandom_range(600, 100)));
            random_phase(PHASE_ITEMS, 1'b0);
        end

        wait_drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
